### hw/rtl/gpr_pkg.sv
// Shared constants, types and codes for the grid path reachability search block.
package gpr_pkg;

   // Grid geometry.
   localparam int GRID_ROWS  = 16;
   localparam int GRID_COLS  = 16;
   localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
   localparam int CELL_W     = $clog2(CELL_COUNT);
   localparam int FILL_W     = $clog2(CELL_COUNT + 1);

   // Field widths as they appear on the ports.
   localparam int ROW_W      = 4;
   localparam int COL_W      = 4;
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 8;

   // Request kinds carried in tuser.
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   // One grid position.
   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } cell_type;

   // Request payload as packed into tdata, lowest field last in this list.
   typedef struct packed {
      logic [REQ_DATA_W-18:0] pad;
      logic [COL_W-1:0]       goal_col;
      logic [ROW_W-1:0]       goal_row;
      logic                   open;
      logic [COL_W-1:0]       col;
      logic [ROW_W-1:0]       row;
   } req_data_type;

   // Commands to the open and visited maps.
   typedef struct packed {
      logic              open_we;
      logic [CELL_W-1:0] open_addr;
      logic              open_wdata;
      logic              visit_we;
      logic [CELL_W-1:0] visit_addr;
      logic              visit_wdata;
      logic [CELL_W-1:0] rd_addr;
   } map_cmd_type;

   // Registered read data of both maps.
   typedef struct packed {
      logic open;
      logic visited;
   } map_rd_type;

   // Commands to the pending stack.
   typedef struct packed {
      logic     clear;
      logic     push;
      logic     pop;
      cell_type push_cell;
   } stk_cmd_type;

   // Pending stack status.
   typedef struct packed {
      logic     empty;
      logic     full;
      cell_type top;
   } stk_sts_type;

   // Neighbor directions in visiting order.
   typedef enum logic [1:0] {
      DIR_UP,
      DIR_DOWN,
      DIR_LEFT,
      DIR_RIGHT
   } dir_type;

   // Search sequencer states.
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_POP,
      ST_CUR,
      ST_SCAN,
      ST_RESULT
   } state_type;

endpackage

### hw/rtl/gpr_cell_maps.sv
// Open-cell map and visited map, each a one-bit synchronous memory.
module gpr_cell_maps (
   input  logic                clock,
   input  gpr_pkg::map_cmd_type cmd,
   output gpr_pkg::map_rd_type  rd
);
   import gpr_pkg::*;

   logic open_mem  [CELL_COUNT];
   logic visit_mem [CELL_COUNT];
   logic open_rd_ff;
   logic visit_rd_ff;

   // Open map: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.open_we) begin
         open_mem[cmd.open_addr] <= cmd.open_wdata;
      end
      open_rd_ff <= open_mem[cmd.rd_addr];
   end

   // Visited map: same shape, read at the same address.
   always_ff @(posedge clock) begin
      if (cmd.visit_we) begin
         visit_mem[cmd.visit_addr] <= cmd.visit_wdata;
      end
      visit_rd_ff <= visit_mem[cmd.rd_addr];
   end

   assign rd.open    = open_rd_ff;
   assign rd.visited = visit_rd_ff;

endmodule

### hw/rtl/gpr_stack.sv
// Pending-cell stack: a synchronous memory with a fill pointer.
module gpr_stack (
   input  logic                 clock,
   input  logic                 reset,
   input  gpr_pkg::stk_cmd_type  cmd,
   output gpr_pkg::stk_sts_type  sts
);
   import gpr_pkg::*;

   cell_type          stack_mem [CELL_COUNT];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] fill_dec;
   logic [CELL_W-1:0] top_addr;
   cell_type          top_ff;
   logic              full;
   logic              empty;

   // Status and the address of the entry on top.
   always_comb begin
      full     = (fill_ff == FILL_W'(CELL_COUNT));
      empty    = (fill_ff == '0);
      fill_dec = fill_ff - FILL_W'(1);
      top_addr = fill_dec[CELL_W-1:0];
   end

   // Fill pointer update; a push onto a full stack is dropped.
   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear) begin
         fill_in = '0;
      end else if (cmd.push && !full) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (cmd.pop && !empty) begin
         fill_in = fill_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Stack storage with a registered read of the top entry on pop.
   always_ff @(posedge clock) begin
      if (cmd.push && !full) begin
         stack_mem[fill_ff[CELL_W-1:0]] <= cmd.push_cell;
      end
      if (cmd.pop && !empty) begin
         top_ff <= stack_mem[top_addr];
      end
   end

   assign sts.empty = empty;
   assign sts.full  = full;
   assign sts.top   = top_ff;

endmodule

### hw/rtl/gpr_walk_ctrl.sv
// Sequencer for maze writes, map clearing and the depth-first walk.
module gpr_walk_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_kind,
   input  gpr_pkg::req_data_type req_data,
   output logic                  req_ready,
   input  gpr_pkg::map_rd_type   map_rd,
   output gpr_pkg::map_cmd_type  map_cmd,
   input  gpr_pkg::stk_sts_type  stk_sts,
   output gpr_pkg::stk_cmd_type  stk_cmd,
   output logic                  res_valid,
   output logic                  res_found,
   input  logic                  res_ready
);
   import gpr_pkg::*;

   // Memory address of a grid position.
   function automatic logic [CELL_W-1:0] cell_addr(input cell_type c);
      int a;
      a = int'(c.row) * GRID_COLS + int'(c.col);
      return a[CELL_W-1:0];
   endfunction

   // True when the neighbor in direction d lies inside the grid.
   function automatic logic nb_inside(input cell_type c, input dir_type d);
      logic ok;
      ok = 1'b0;
      unique case (d)
         DIR_UP:    ok = (c.row != '0);
         DIR_DOWN:  ok = (int'(c.row) + 1 < GRID_ROWS);
         DIR_LEFT:  ok = (c.col != '0);
         DIR_RIGHT: ok = (int'(c.col) + 1 < GRID_COLS);
         default:   ok = 1'b0;
      endcase
      return ok;
   endfunction

   // Neighbor position in direction d.
   function automatic cell_type nb_cell(input cell_type c, input dir_type d);
      cell_type n;
      n = c;
      unique case (d)
         DIR_UP:    n.row = c.row - ROW_W'(1);
         DIR_DOWN:  n.row = c.row + ROW_W'(1);
         DIR_LEFT:  n.col = c.col - COL_W'(1);
         DIR_RIGHT: n.col = c.col + COL_W'(1);
         default:   n = c;
      endcase
      return n;
   endfunction

   state_type         state_ff;
   state_type         state_in;
   logic [CELL_W-1:0] clr_addr_ff;
   logic [CELL_W-1:0] clr_addr_in;
   cell_type          start_ff;
   cell_type          start_in;
   cell_type          goal_ff;
   cell_type          goal_in;
   logic              goal_ok_ff;
   logic              goal_ok_in;
   logic              found_ff;
   logic              found_in;
   cell_type          cur_ff;
   cell_type          cur_in;
   dir_type           issue_dir_ff;
   dir_type           issue_dir_in;
   logic              issue_more_ff;
   logic              issue_more_in;
   logic              chk_valid_ff;
   logic              chk_valid_in;
   cell_type          chk_cell_ff;
   cell_type          chk_cell_in;

   cell_type          req_cell;
   cell_type          req_goal;
   logic              req_in_grid;
   logic              clr_last;
   logic              goal_hit;
   logic              can_push;

   // Decoded request fields and shared conditions.
   always_comb begin
      req_cell.row = req_data.row;
      req_cell.col = req_data.col;
      req_goal.row = req_data.goal_row;
      req_goal.col = req_data.goal_col;
      req_in_grid  = (int'(req_data.row) < GRID_ROWS) && (int'(req_data.col) < GRID_COLS);
      clr_last     = (clr_addr_ff == CELL_W'(CELL_COUNT - 1));
      goal_hit     = goal_ok_ff && (stk_sts.top == goal_ff);
      can_push     = chk_valid_ff && map_rd.open && !map_rd.visited && !stk_sts.full;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid && req_kind == KIND_SEARCH) begin
               state_in = req_in_grid ? ST_CLEAR : ST_RESULT;
            end
         end
         ST_CLEAR: begin
            if (clr_last) state_in = ST_SEED;
         end
         ST_SEED: state_in = ST_POP;
         ST_POP: begin
            state_in = stk_sts.empty ? ST_RESULT : ST_CUR;
         end
         ST_CUR: begin
            state_in = goal_hit ? ST_RESULT : ST_SCAN;
         end
         ST_SCAN: begin
            if (!issue_more_ff) state_in = ST_POP;
         end
         ST_RESULT: begin
            if (res_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: handshake, map and stack commands.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      map_cmd   = '0;
      stk_cmd   = '0;
      unique case (state_ff)
         ST_INIT: begin
            map_cmd.open_we   = 1'b1;
            map_cmd.open_addr = clr_addr_ff;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid && req_kind == KIND_WRITE && req_in_grid) begin
               map_cmd.open_we    = 1'b1;
               map_cmd.open_addr  = cell_addr(req_cell);
               map_cmd.open_wdata = req_data.open;
            end
         end
         ST_CLEAR: begin
            map_cmd.visit_we   = 1'b1;
            map_cmd.visit_addr = clr_addr_ff;
            stk_cmd.clear      = 1'b1;
         end
         ST_SEED: begin
            stk_cmd.push        = 1'b1;
            stk_cmd.push_cell   = start_ff;
            map_cmd.visit_we    = 1'b1;
            map_cmd.visit_addr  = cell_addr(start_ff);
            map_cmd.visit_wdata = 1'b1;
         end
         ST_POP: begin
            stk_cmd.pop = !stk_sts.empty;
         end
         ST_CUR: begin
            res_valid = 1'b0;
         end
         ST_SCAN: begin
            // Read the next neighbor while the previous one is checked.
            map_cmd.rd_addr = cell_addr(nb_cell(cur_ff, issue_dir_ff));
            if (can_push) begin
               stk_cmd.push        = 1'b1;
               stk_cmd.push_cell   = chk_cell_ff;
               map_cmd.visit_we    = 1'b1;
               map_cmd.visit_addr  = cell_addr(chk_cell_ff);
               map_cmd.visit_wdata = 1'b1;
            end
         end
         ST_RESULT: begin
            res_valid = 1'b1;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   // Datapath registers of the walk.
   always_comb begin
      clr_addr_in   = '0;
      start_in      = start_ff;
      goal_in       = goal_ff;
      goal_ok_in    = goal_ok_ff;
      found_in      = found_ff;
      cur_in        = cur_ff;
      issue_dir_in  = issue_dir_ff;
      issue_more_in = issue_more_ff;
      chk_valid_in  = 1'b0;
      chk_cell_in   = chk_cell_ff;

      if (state_ff == ST_INIT || state_ff == ST_CLEAR) begin
         clr_addr_in = clr_last ? '0 : clr_addr_ff + CELL_W'(1);
      end

      if (state_ff == ST_IDLE && req_valid && req_kind == KIND_SEARCH) begin
         start_in   = req_cell;
         goal_in    = req_goal;
         goal_ok_in = (int'(req_data.goal_row) < GRID_ROWS) &&
                      (int'(req_data.goal_col) < GRID_COLS);
         found_in   = 1'b0;
      end

      if (state_ff == ST_CUR) begin
         cur_in        = stk_sts.top;
         issue_dir_in  = DIR_UP;
         issue_more_in = !goal_hit;
         if (goal_hit) found_in = 1'b1;
      end

      if (state_ff == ST_SCAN && issue_more_ff) begin
         chk_valid_in  = nb_inside(cur_ff, issue_dir_ff);
         chk_cell_in   = nb_cell(cur_ff, issue_dir_ff);
         issue_more_in = (issue_dir_ff != DIR_RIGHT);
         issue_dir_in  = dir_type'(issue_dir_ff + 2'd1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         clr_addr_ff   <= '0;
         issue_more_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         issue_more_ff <= issue_more_in;
         chk_valid_ff  <= chk_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      goal_ff      <= goal_in;
      goal_ok_ff   <= goal_ok_in;
      found_ff     <= found_in;
      cur_ff       <= cur_in;
      issue_dir_ff <= issue_dir_in;
      chk_cell_ff  <= chk_cell_in;
   end

   assign res_found = found_ff;

endmodule

### hw/rtl/grid_path_reachability_dfs.sv
// Top level of the grid maze reachability search block.
// The block keeps a 16 x 16 maze of open and wall cells and answers whether a
// goal cell can be reached from a start cell by up, down, left, right moves.
// Requests arrive on the req_ stream; tuser selects a cell write (0) or a
// search (1). A write gives no response. A search gives exactly one response
// on the rsp_ stream with path_found in rsp_tdata bit 0. A search first
// clears the visited map, one entry a cycle, seeds the stack, and then works
// through each cell it pops in steps: a stack read, a goal compare, and a
// scan that streams the four neighbor reads of the map memories through a
// registered read and a check stage. One request is worked on at a time.
// After reset the block clears the open map with req_tready low; every cell
// then reads as a wall.
// The response sits in an output register: while the receiver stalls, the
// block still accepts further requests, and a finished search waits until the
// register is free.
module grid_path_reachability_dfs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // row[3:0], col[7:4], open[8], goal_row[12:9], goal_col[16:13], zero pad
   input  logic [gpr_pkg::REQ_DATA_W-1:0] req_tdata,
   // kind[0]
   input  logic [gpr_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // path_found[0], zero pad
   output logic [gpr_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import gpr_pkg::*;

   req_data_type req_data;
   map_cmd_type  map_cmd;
   map_rd_type   map_rd;
   stk_cmd_type  stk_cmd;
   stk_sts_type  stk_sts;
   logic         res_valid;
   logic         res_found;
   logic         res_ready;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   logic         rsp_found_ff;

   assign req_data = req_data_type'(req_tdata);

   gpr_cell_maps u_maps (
      .clock (clock),
      .cmd   (map_cmd),
      .rd    (map_rd)
   );

   gpr_stack u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stk_cmd),
      .sts   (stk_sts)
   );

   gpr_walk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_kind  (req_tuser[0]),
      .req_data  (req_data),
      .req_ready (req_tready),
      .map_rd    (map_rd),
      .map_cmd   (map_cmd),
      .stk_sts   (stk_sts),
      .stk_cmd   (stk_cmd),
      .res_valid (res_valid),
      .res_found (res_found),
      .res_ready (res_ready)
   );

   // Output register: loads a finished search when empty or being drained.
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_tready;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_found_ff <= res_found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_found_ff);

`ifndef SYNTHESIS
   // Each cell is pushed at most once, so a push never meets a full stack.
   assert property (@(posedge clock) disable iff (reset)
      stk_cmd.push |-> !stk_sts.full)
      else $error("push onto a full stack");

   // The stack is never pushed and popped in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      !(stk_cmd.push && stk_cmd.pop))
      else $error("stack push and pop together");

   // No request is taken while a search result is being handed over.
   assert property (@(posedge clock) disable iff (reset)
      res_valid |-> !req_tready)
      else $error("request accepted while a result is pending");

   // A result loaded into the output register shows up in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (rsp_tvalid && rsp_tdata[0] == $past(res_found)))
      else $error("response register lost a result");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the grid maze reachability search block.
module tb;
   import gpr_pkg::*;

   // One request to the block: a cell write or a search.
   typedef struct {
      logic             kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic             open;
      logic [ROW_W-1:0] goal_row;
      logic [COL_W-1:0] goal_col;
      bit               drain;
   } maze_request_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   // Requests still to be offered, and the path_found values still owed.
   maze_request_type request_backlog[$];
   bit               predicted_found[$];

   // Predicted maze: one bit per cell, 1 for an open passage.
   bit               open_cells[0:CELL_COUNT-1];

   maze_request_type current_req;
   req_data_type     payload;
   int               send_gap;
   bit               send_burst;
   int               hold_left;
   bit               take_burst;
   int               responses_seen;
   int               error_count;

   grid_path_reachability_dfs u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Depth-first walk over the predicted maze. The start is never checked for
   // a wall; every step after it only enters open, unvisited cells.
   function automatic bit reach_goal(input logic [ROW_W-1:0] start_row,
                                     input logic [COL_W-1:0] start_col,
                                     input logic [ROW_W-1:0] goal_row,
                                     input logic [COL_W-1:0] goal_col);
      bit                seen[0:CELL_COUNT-1];
      logic [CELL_W-1:0] stack_cells[$];
      logic [CELL_W-1:0] cur;
      logic [CELL_W-1:0] next_cell;
      int                cur_row;
      int                cur_col;
      int                nr;
      int                nc;
      bit                hit;
      hit = 1'b0;
      foreach (seen[i]) seen[i] = 1'b0;
      stack_cells.push_back({start_row, start_col});
      seen[{start_row, start_col}] = 1'b1;
      while (stack_cells.size() != 0 && !hit) begin
         cur = stack_cells.pop_back();
         if (cur == {goal_row, goal_col}) begin
            hit = 1'b1;
         end else begin
            cur_row = int'(cur[CELL_W-1:COL_W]);
            cur_col = int'(cur[COL_W-1:0]);
            for (int d = 0; d < 4; d++) begin
               nr = cur_row;
               nc = cur_col;
               case (dir_type'(d))
                  DIR_UP:    nr = cur_row - 1;
                  DIR_DOWN:  nr = cur_row + 1;
                  DIR_LEFT:  nc = cur_col - 1;
                  DIR_RIGHT: nc = cur_col + 1;
               endcase
               if (nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS) begin
                  next_cell = CELL_W'(nr * GRID_COLS + nc);
                  if (open_cells[next_cell] && !seen[next_cell]) begin
                     stack_cells.push_back(next_cell);
                     seen[next_cell] = 1'b1;
                  end
               end
            end
         end
      end
      return hit;
   endfunction

   // Update the predicted maze, or queue the answer a search must give.
   function automatic void apply_request(input maze_request_type r);
      if (r.kind == KIND_WRITE) begin
         open_cells[{r.row, r.col}] = r.open;
      end else begin
         predicted_found.push_back(reach_goal(r.row, r.col, r.goal_row, r.goal_col));
      end
   endfunction

   // Queue a cell write; the goal fields are unused and carry noise.
   function automatic void add_write(input int row, input int col, input bit open,
                                     input bit drain = 1'b0);
      maze_request_type r;
      r.kind     = KIND_WRITE;
      r.row      = ROW_W'(row);
      r.col      = COL_W'(col);
      r.open     = open;
      r.goal_row = ROW_W'($urandom_range(0, GRID_ROWS - 1));
      r.goal_col = COL_W'($urandom_range(0, GRID_COLS - 1));
      r.drain    = drain;
      request_backlog.push_back(r);
   endfunction

   // Queue a search; the open bit is unused and carries noise.
   function automatic void add_search(input int start_row, input int start_col,
                                      input int goal_row, input int goal_col,
                                      input bit drain = 1'b0);
      maze_request_type r;
      r.kind     = KIND_SEARCH;
      r.row      = ROW_W'(start_row);
      r.col      = COL_W'(start_col);
      r.open     = ($urandom_range(0, 1) == 1);
      r.goal_row = ROW_W'(goal_row);
      r.goal_col = COL_W'(goal_col);
      r.drain    = drain;
      request_backlog.push_back(r);
   endfunction

   // Request driver: offers the backlog with random gaps between requests.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(current_req);
            if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
            send_gap = send_burst ? 0 : $urandom_range(0, 7);
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0 &&
                         (!request_backlog[0].drain || predicted_found.size() == 0)) begin
               current_req      = request_backlog.pop_front();
               payload          = '0;
               payload.row      = current_req.row;
               payload.col      = current_req.col;
               payload.open     = current_req.open;
               payload.goal_row = current_req.goal_row;
               payload.goal_col = current_req.goal_col;
               req_tdata  <= payload;
               req_tuser  <= current_req.kind;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: checks each answer and stalls the block at random.
   // The stall counts only while a response is waiting; once, it is long
   // enough for the block to finish another search and back up its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_found.size() == 0) begin
               $error("path_found: expected none, actual %0d", rsp_tdata[0]);
               error_count++;
            end else if (rsp_tdata[0] !== predicted_found[0]) begin
               $error("path_found: expected %0d, actual %0d",
                      predicted_found[0], rsp_tdata[0]);
               error_count++;
               void'(predicted_found.pop_front());
            end else begin
               void'(predicted_found.pop_front());
            end
            responses_seen++;
            if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
            if (responses_seen == 30) hold_left = 6000;
            else hold_left = take_burst ? 0 : $urandom_range(0, 7);
         end else if (rsp_tvalid && hold_left > 0) begin
            hold_left--;
         end
         rsp_tready <= (hold_left == 0);
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int action;
      int r0;
      int c0;
      int len;
      bit vertical;

      // Directed part on an all-wall maze.
      add_search(5, 5, 5, 5);
      add_search(0, 0, 15, 15);
      add_search(0, 0, 0, 1);
      add_write(0, 1, 1'b1);
      add_search(0, 0, 0, 1);
      add_write(7, 8, 1'b1);
      add_write(9, 8, 1'b1);
      add_write(8, 7, 1'b1);
      add_write(8, 9, 1'b1);
      add_search(8, 8, 7, 8);
      add_search(8, 8, 9, 8);
      add_search(8, 8, 8, 7);
      add_search(8, 8, 8, 9);
      add_write(9, 8, 1'b0);
      add_search(8, 8, 9, 8);
      add_write(15, 15, 1'b1);
      add_write(15, 14, 1'b1);
      add_search(15, 14, 15, 15);
      add_search(15, 15, 0, 0);
      add_search(0, 15, 15, 0);

      // Random part: mostly open corridors followed by a search from them,
      // mixed with scattered writes and searches between random cells.
      while (request_backlog.size() < 580) begin
         action = $urandom_range(0, 99);
         if (action < 40) begin
            r0       = $urandom_range(0, GRID_ROWS - 1);
            c0       = $urandom_range(0, GRID_COLS - 1);
            len      = $urandom_range(2, 6);
            vertical = ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++) begin
               add_write(vertical ? (r0 + i) % GRID_ROWS : r0,
                         vertical ? c0 : (c0 + i) % GRID_COLS,
                         $urandom_range(0, 4) != 0);
            end
            if ($urandom_range(0, 1) == 1) begin
               add_search(r0, c0, $urandom_range(0, GRID_ROWS - 1),
                          $urandom_range(0, GRID_COLS - 1));
            end else begin
               add_search(r0, c0, vertical ? (r0 + len - 1) % GRID_ROWS : r0,
                          vertical ? c0 : (c0 + len - 1) % GRID_COLS);
            end
         end else if (action < 75) begin
            add_write($urandom_range(0, GRID_ROWS - 1), $urandom_range(0, GRID_COLS - 1),
                      $urandom_range(0, 99) < 65);
         end else begin
            r0 = $urandom_range(0, GRID_ROWS - 1);
            c0 = $urandom_range(0, GRID_COLS - 1);
            if ($urandom_range(0, 15) == 0) begin
               add_search(r0, c0, r0, c0);
            end else begin
               add_search(r0, c0, $urandom_range(0, GRID_ROWS - 1),
                          $urandom_range(0, GRID_COLS - 1));
            end
         end
      end

      // The sender waits for all answers before the random part and midway.
      request_backlog[20].drain  = 1'b1;
      request_backlog[300].drain = 1'b1;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request and answer, then watch for stray responses.
      @(posedge clock);
      while (request_backlog.size() != 0 || req_tvalid || predicted_found.size() != 0) begin
         @(posedge clock);
      end
      repeat (2100) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

endmodule

### files.f
hw/rtl/gpr_pkg.sv
hw/rtl/gpr_cell_maps.sv
hw/rtl/gpr_stack.sv
hw/rtl/gpr_walk_ctrl.sv
hw/rtl/grid_path_reachability_dfs.sv
tb/tb.sv
